// File: rtl/pota_pkg.sv
package pota_pkg;

  localparam int unsigned QBits = 32;

  typedef struct packed {
    logic [2:0][63:0] mag;
    logic [2:0]       neg;
    logic [2:0][63:0] len;
  } item_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(div_t s, logic [63:0] len);
    logic [64:0] t;
    div_t        r;
    t     = {s.rem, s.low[31]};
    r.low = {s.low[30:0], 1'b0};
    if (t >= {1'b0, len}) begin
      r.rem = 64'(t - {1'b0, len});
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t[63:0];
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/pota_in_if.sv
interface pota_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] row0_x;
  logic signed [31:0] row0_y;
  logic signed [31:0] row0_z;
  logic signed [31:0] row1_x;
  logic signed [31:0] row1_y;
  logic signed [31:0] row1_z;
  logic signed [31:0] row2_x;
  logic signed [31:0] row2_y;
  logic signed [31:0] row2_z;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                  row2_x, row2_y, row2_z, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, row0_x, row0_y, row0_z, row1_x, row1_y, row1_z,
                row2_x, row2_y, row2_z, vec_x, vec_y, vec_z, output ready);
endinterface

// File: rtl/pota_out_if.sv
interface pota_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_x;
  logic signed [31:0] coef_y;
  logic signed [31:0] coef_z;
  logic        [2:0]  zero_axis_mask;

  modport source (output valid, coef_x, coef_y, coef_z, zero_axis_mask, input ready);
  modport sink (input valid, coef_x, coef_y, coef_z, zero_axis_mask, output ready);
endinterface

// File: rtl/pota_front.sv
module pota_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  pota_in_if.sink         in_i,
  output pota_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_ready_i
);

  logic signed [31:0] row [3][3];
  logic signed [31:0] vec [3];
  logic signed [63:0] dp_q [3][3];
  logic signed [63:0] lp_q [3][3];
  logic               v1_q;
  logic               v2_q;
  logic               en;
  logic signed [65:0] dsum [3];
  logic [63:0]        lsum [3];
  pota_pkg::item_t    item_d;
  pota_pkg::item_t    item_q;

  assign row[0][0] = in_i.row0_x;
  assign row[0][1] = in_i.row0_y;
  assign row[0][2] = in_i.row0_z;
  assign row[1][0] = in_i.row1_x;
  assign row[1][1] = in_i.row1_y;
  assign row[1][2] = in_i.row1_z;
  assign row[2][0] = in_i.row2_x;
  assign row[2][1] = in_i.row2_y;
  assign row[2][2] = in_i.row2_z;
  assign vec[0]    = in_i.vec_x;
  assign vec[1]    = in_i.vec_y;
  assign vec[2]    = in_i.vec_z;

  assign en         = !v2_q || item_ready_i;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          dp_q[k][j] <= 64'(row[k][j]) * 64'(vec[j]);
          lp_q[k][j] <= 64'(row[k][j]) * 64'(row[k][j]);
        end
      end
      item_q <= item_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsum[k] = 66'(dp_q[k][0]) + 66'(dp_q[k][1]) + 66'(dp_q[k][2]);
      lsum[k] = 64'(lp_q[k][0]) + 64'(lp_q[k][1]) + 64'(lp_q[k][2]);
      item_d.neg[k] = dsum[k][65];
      item_d.mag[k] = dsum[k][65] ? 64'(-dsum[k]) : 64'(dsum[k]);
      item_d.len[k] = lsum[k];
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = v2_q;

endmodule

// File: rtl/pota_fifo.sv
module pota_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pota_pkg::item_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output pota_pkg::item_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  pota_pkg::item_t mem_q [2];
  logic            wp_q;
  logic            rp_q;
  logic [1:0]      cnt_q;
  logic            push;
  logic            pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= push_data_i;
  end

endmodule

// File: rtl/pota_back.sv
module pota_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pota_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  pota_out_if.source      out_o
);

  localparam int unsigned NStg = pota_pkg::QBits;

  pota_pkg::div_t       st_q  [NStg+1][3];
  logic [63:0]          len_q [NStg+1][3];
  logic [2:0]           neg_q [NStg+1];
  logic [2:0]           sat_q [NStg+1];
  logic [NStg:0]        vld_q;
  logic                 out_valid_q;
  logic signed [31:0]   coef_q [3];
  logic [2:0]           mask_q;
  logic                 en;
  logic [63+FRAC_BITS:0] num [3];
  pota_pkg::div_t       init [3];
  logic signed [31:0]   coef_d [3];
  logic [2:0]           mask_d;

  assign en           = !out_valid_q || out_o.ready;
  assign item_ready_o = en;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k]      = {item_i.mag[k], {FRAC_BITS{1'b0}}};
      init[k].rem = 64'(num[k][63+FRAC_BITS:32]);
      init[k].low = num[k][31:0];
      init[k].quo = 32'd0;
    end
  end

  // final saturation and zero-length axis masking
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mask_d[k] = len_q[NStg][k] == 64'd0;
      if (mask_d[k]) begin
        coef_d[k] = 32'sd0;
      end else if (neg_q[NStg][k]) begin
        if (sat_q[NStg][k] || st_q[NStg][k].quo[31]) coef_d[k] = 32'sh8000_0000;
        else coef_d[k] = signed'(32'(-st_q[NStg][k].quo));
      end else begin
        if (sat_q[NStg][k] || st_q[NStg][k].quo[31]) coef_d[k] = 32'sh7fff_ffff;
        else coef_d[k] = signed'(st_q[NStg][k].quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NStg-1:0], item_valid_i};
      out_valid_q <= vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        st_q[0][k]  <= init[k];
        len_q[0][k] <= item_i.len[k];
        sat_q[0][k] <= init[k].rem >= item_i.len[k];
      end
      neg_q[0] <= item_i.neg;
      for (int s = 1; s <= NStg; s++) begin
        for (int k = 0; k < 3; k++) begin
          st_q[s][k]  <= pota_pkg::div_step(st_q[s-1][k], len_q[s-1][k]);
          len_q[s][k] <= len_q[s-1][k];
        end
        neg_q[s] <= neg_q[s-1];
        sat_q[s] <= sat_q[s-1];
      end
      coef_q <= coef_d;
      mask_q <= mask_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.coef_x         = coef_q[0];
  assign out_o.coef_y         = coef_q[1];
  assign out_o.coef_z         = coef_q[2];
  assign out_o.zero_axis_mask = mask_q;

endmodule

// File: rtl/project_onto_three_axes_top.sv
// throughput: one item per cycle while out_o.ready is not held low, set by the 18 pipelined multipliers
// and the three 32-stage restoring divider pipelines
// a two-entry queue sits between the dot-product front and the divider back
// reset clears only valid flags, queue pointers and queue count; no clearing pass
module project_onto_three_axes_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pota_in_if.sink     in_i,
  pota_out_if.source  out_o
);

  pota_pkg::item_t f_item;
  logic            f_valid;
  logic            f_ready;
  pota_pkg::item_t b_item;
  logic            b_valid;
  logic            b_ready;

  pota_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  pota_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_item),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (b_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  pota_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (b_item),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .out_o        (out_o)
  );

endmodule
